@@ sv/tdrf_pkg.sv @@
// ---------------------------------------------------------------------------
// tdrf_pkg: shared types and constants of the throw detector
// Field widths, register indexes, roll phases and the controller/datapath
// command and status records.
// ---------------------------------------------------------------------------
`default_nettype none

package tdrf_pkg;

  localparam int JERK_W  = 13;
  localparam int TIME_W  = 32;
  localparam int FACE_W  = 5;
  localparam int LEVEL_W = 26;
  localparam int SQ_W    = 25;
  localparam int DECAY_W = 16;
  localparam int MS_W    = 16;
  localparam int FTH_W   = 11;
  localparam int ROLL_W  = 2;
  localparam int OUT_W   = 40;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 26;

  localparam int FACE_COUNT = 20;
  localparam logic [FACE_W-1:0]  ANIM_OFFSET = 5'd6;
  localparam logic [DECAY_W:0]   DECAY_ONE   = 17'h10000;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DECAY_START = 3'd0;
  localparam logic [IDX_W-1:0] REG_DECAY_STOP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_THR   = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_THR     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_ROLL    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FACE_THR    = 3'd5;

  typedef enum logic [ROLL_W-1:0] {
    PH_ON_FACE = 2'd0,
    PH_STARTED = 2'd1,
    PH_ROLLED  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_HI,
    ST_E,
    ST_ACC,
    ST_UPD
  } ctrl_state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MOP_IDLE,
    MOP_LO,
    MOP_HI,
    MOP_E
  } mop_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    AOP_HOLD,
    AOP_LOAD,
    AOP_ADD_HI,
    AOP_ADD_E
  } aop_t;

  typedef struct packed {
    logic cap;
    logic sq;
    mop_t mop;
    aop_t aop;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/throw_detector_roll_fsm_unit.sv @@
// ---------------------------------------------------------------------------
// throw_detector_roll_fsm_unit: die throw detector on accelerometer frames
// Smooths jerk energy, tracks the roll phase and flags landings.
// ---------------------------------------------------------------------------
// Usage:
//   Input frames arrive on the s_ stream; each transfer is one frame. Every
//   frame yields exactly one result transfer on the m_ stream with the new
//   roll phase, the landing flag, the animation index and the integer part
//   of the smoothed jerk energy.
//   A frame goes through capture, squaring, three passes through the single
//   shared multiplier (two halves of the average times the decay, energy
//   times its complement), accumulation and the phase update before the next
//   frame can be taken. The result shows on m_tvalid once the phase update
//   has loaded the output register.
//   A held result sits in the output register while the next frame is
//   already taken and processed; only the update of that frame waits until
//   the output register is free.
//   Reset clears the average, the phase (on face), the roll start time and
//   loads the register defaults. Registers are written through cfg_we,
//   cfg_index and cfg_data while no frame is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module throw_detector_roll_fsm_unit
  import tdrf_pkg::*;
#(
  parameter int ACCEL_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         s_tvalid,
  output logic                                              s_tready,
  // jerk_x, jerk_y, jerk_z, accel_x, accel_y, accel_z, time_ms, current_face
  input  wire logic [((3*JERK_W+3*ACCEL_BITS+TIME_W+FACE_W+7)/8)*8-1:0]
                                                            s_tdata,
  output logic                                              m_tvalid,
  input  wire logic                                         m_tready,
  // roll_state, landed, anim_index, energy_level
  output logic [OUT_W-1:0]                                  m_tdata,
  input  wire logic                                         cfg_we,
  input  wire logic [IDX_W-1:0]                             cfg_index,
  input  wire logic [CFG_W-1:0]                             cfg_data
);

  localparam int IN_W = ((3*JERK_W + 3*ACCEL_BITS + TIME_W + FACE_W + 7) / 8) * 8;

  logic [DECAY_W-1:0] decay_start;
  logic [DECAY_W-1:0] decay_stop;
  logic [LEVEL_W-1:0] start_threshold;
  logic [LEVEL_W-1:0] end_threshold;
  logic [MS_W-1:0]    min_roll_ms;
  logic [FTH_W-1:0]   face_threshold;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_start     <= 16'd62259;
      decay_stop      <= 16'd62259;
      start_threshold <= 26'd1000000;
      end_threshold   <= 26'd500000;
      min_roll_ms     <= 16'd300;
      face_threshold  <= 11'd1600;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY_START: decay_start     <= cfg_data[DECAY_W-1:0];
        REG_DECAY_STOP:  decay_stop      <= cfg_data[DECAY_W-1:0];
        REG_START_THR:   start_threshold <= cfg_data[LEVEL_W-1:0];
        REG_END_THR:     end_threshold   <= cfg_data[LEVEL_W-1:0];
        REG_MIN_ROLL:    min_roll_ms     <= cfg_data[MS_W-1:0];
        REG_FACE_THR:    face_threshold  <= cfg_data[FTH_W-1:0];
        default: ;
      endcase
    end
  end

  tdrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdrf_dp #(
    .ACCEL_BITS (ACCEL_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .IN_W       (IN_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_data         (s_tdata),
    .decay_start     (decay_start),
    .decay_stop      (decay_stop),
    .start_threshold (start_threshold),
    .end_threshold   (end_threshold),
    .min_roll_ms     (min_roll_ms),
    .face_threshold  (face_threshold),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

`default_nettype wire

@@ sv/tdrf_ctrl.sv @@
// ---------------------------------------------------------------------------
// tdrf_ctrl: sequencing controller of the throw detector
// Walks one frame through capture, squaring, three multiply passes and the
// phase update, and holds the update until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module tdrf_ctrl
  import tdrf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '{cap: 1'b0, sq: 1'b0, mop: MOP_IDLE, aop: AOP_HOLD, commit: 1'b0};
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap    = 1'b1;
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        cmd.mop    = MOP_LO;
        state_next = ST_HI;
      end
      ST_HI: begin
        cmd.mop    = MOP_HI;
        cmd.aop    = AOP_LOAD;
        state_next = ST_E;
      end
      ST_E: begin
        cmd.mop    = MOP_E;
        cmd.aop    = AOP_ADD_HI;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.aop    = AOP_ADD_E;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/tdrf_dp.sv @@
// ---------------------------------------------------------------------------
// tdrf_dp: datapath of the throw detector
// Input capture, jerk squares, one shared multiplier for the moving
// average, the roll phase state and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tdrf_dp
  import tdrf_pkg::*;
#(
  parameter int ACCEL_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int IN_W       = 112
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat,
  input  wire logic [IN_W-1:0]      in_data,
  input  wire logic [DECAY_W-1:0]   decay_start,
  input  wire logic [DECAY_W-1:0]   decay_stop,
  input  wire logic [LEVEL_W-1:0]   start_threshold,
  input  wire logic [LEVEL_W-1:0]   end_threshold,
  input  wire logic [MS_W-1:0]      min_roll_ms,
  input  wire logic [FTH_W-1:0]     face_threshold,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [OUT_W-1:0]          m_tdata
);

  localparam int AVG_W   = LEVEL_W + FRAC_BITS;
  localparam int HALF    = (AVG_W + 1) / 2;
  localparam int HI_W    = AVG_W - HALF;
  localparam int MUL_A_W = (HALF > LEVEL_W) ? HALF : LEVEL_W;
  localparam int MUL_B_W = DECAY_W + 1;
  localparam int P_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = AVG_W + DECAY_W;
  localparam int CMP_W   = (ACCEL_BITS > FTH_W) ? ACCEL_BITS : FTH_W;
  localparam int OFF_AX  = 3 * JERK_W;
  localparam int OFF_T   = OFF_AX + 3 * ACCEL_BITS;
  localparam int OFF_F   = OFF_T + TIME_W;

  function automatic logic [ACCEL_BITS-1:0] mag(input logic [ACCEL_BITS-1:0] v);
    return v[ACCEL_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Captured frame.
  logic signed [JERK_W-1:0] jx, jy, jz;
  logic [ACCEL_BITS-1:0]    ax, ay, az;
  logic [TIME_W-1:0]        now;
  logic [FACE_W-1:0]        face;

  // Derived per-frame values.
  logic [SQ_W-1:0]    sqx, sqy, sqz;
  logic [LEVEL_W-1:0] energy;
  logic               accel_hit;
  logic               time_gt;

  // Model state.
  logic [AVG_W-1:0]  energy_avg;
  phase_t            phase;
  logic [TIME_W-1:0] roll_start_ms;

  // Multiplier and accumulator.
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [P_W-1:0]       prod;
  logic [ACC_W+P_W-1:0] prod_ext;
  logic [ACC_W-1:0]     acc;
  logic [DECAY_W-1:0]   decay;

  logic signed [2*JERK_W-1:0] sqx_full, sqy_full, sqz_full;

  // Output register.
  logic [ROLL_W-1:0]  out_phase;
  logic               out_landed;
  logic [FACE_W-1:0]  out_anim;
  logic [LEVEL_W-1:0] out_level;

  // Update results.
  logic [AVG_W-1:0]   avg_new;
  logic [LEVEL_W-1:0] level_new;
  phase_t             phase_next;
  logic               landed_next;
  logic [FACE_W-1:0]  anim_next;
  logic               rs_load;
  logic               face_ok;

  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      jx   <= $signed(in_data[0 +: JERK_W]);
      jy   <= $signed(in_data[JERK_W +: JERK_W]);
      jz   <= $signed(in_data[2*JERK_W +: JERK_W]);
      ax   <= in_data[OFF_AX +: ACCEL_BITS];
      ay   <= in_data[OFF_AX + ACCEL_BITS +: ACCEL_BITS];
      az   <= in_data[OFF_AX + 2*ACCEL_BITS +: ACCEL_BITS];
      now  <= in_data[OFF_T +: TIME_W];
      face <= in_data[OFF_F +: FACE_W];
    end
  end

  assign sqx_full = jx * jx;
  assign sqy_full = jy * jy;
  assign sqz_full = jz * jz;

  always_ff @(posedge clk) begin
    if (cmd.sq) begin
      sqx       <= sqx_full[SQ_W-1:0];
      sqy       <= sqy_full[SQ_W-1:0];
      sqz       <= sqz_full[SQ_W-1:0];
      time_gt   <= (now - roll_start_ms) > TIME_W'(min_roll_ms);
      accel_hit <= (CMP_W'(mag(ax)) > CMP_W'(face_threshold)) ||
                   (CMP_W'(mag(ay)) > CMP_W'(face_threshold)) ||
                   (CMP_W'(mag(az)) > CMP_W'(face_threshold));
    end
    if (cmd.mop == MOP_HI) begin
      energy <= LEVEL_W'(sqx) + LEVEL_W'(sqy) + LEVEL_W'(sqz);
    end
  end

  // Rolled phase uses its own decay; any other code uses the start decay.
  assign decay = (phase == PH_ROLLED) ? decay_stop : decay_start;

  // avg' = (avg*d + (e << FRAC_BITS)*(1 - d)) >> 16, with avg*d split into
  // two half-width products so the multiplier stays narrow.
  always_comb begin
    mul_b = {1'b0, decay};
    case (cmd.mop)
      MOP_LO:  mul_a = MUL_A_W'(energy_avg[HALF-1:0]);
      MOP_HI:  mul_a = MUL_A_W'(energy_avg[AVG_W-1 -: HI_W]);
      MOP_E: begin
        mul_a = MUL_A_W'(energy);
        mul_b = DECAY_ONE - {1'b0, decay};
      end
      default: mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mop != MOP_IDLE) begin
      prod <= mul_a * mul_b;
    end
  end

  assign prod_ext = {{ACC_W{1'b0}}, prod};

  always_ff @(posedge clk) begin
    case (cmd.aop)
      AOP_LOAD:   acc <= ACC_W'(prod_ext);
      AOP_ADD_HI: acc <= acc + ACC_W'(prod_ext << HALF);
      AOP_ADD_E:  acc <= acc + ACC_W'(prod_ext << FRAC_BITS);
      default:    acc <= acc;
    endcase
  end

  assign avg_new   = acc[DECAY_W +: AVG_W];
  assign level_new = avg_new[FRAC_BITS +: LEVEL_W];
  assign face_ok   = {1'b0, face} < (FACE_W + 1)'(FACE_COUNT);

  // Comparing the integer part equals comparing against threshold << FRAC_BITS.
  always_comb begin
    phase_next  = phase;
    landed_next = 1'b0;
    anim_next   = '0;
    rs_load     = 1'b0;
    unique case (phase)
      PH_STARTED: begin
        if (level_new < start_threshold) begin
          phase_next = PH_ON_FACE;
        end else if (time_gt) begin
          phase_next = PH_ROLLED;
        end
      end
      PH_ROLLED: begin
        if (level_new < end_threshold) begin
          phase_next = PH_ON_FACE;
          if (accel_hit && face_ok) begin
            landed_next = 1'b1;
            anim_next   = face + ANIM_OFFSET;
          end
        end
      end
      default: begin
        phase_next = PH_ON_FACE;
        if (level_new >= start_threshold) begin
          phase_next = PH_STARTED;
          rs_load    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_avg    <= '0;
      phase         <= PH_ON_FACE;
      roll_start_ms <= '0;
    end else if (cmd.commit) begin
      energy_avg <= avg_new;
      phase      <= phase_next;
      if (rs_load) begin
        roll_start_ms <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_phase  <= phase_next;
      out_landed <= landed_next;
      out_anim   <= anim_next;
      out_level  <= level_new;
    end
  end

  assign m_tdata = {(OUT_W - LEVEL_W - FACE_W - 1 - ROLL_W)'(0),
                    out_level, out_anim, out_landed, out_phase};

  a_landed_on_face: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_landed) |-> (out_phase == PH_ON_FACE))
    else $error("landing reported outside the on-face phase");

  a_anim_only_landed: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_landed) |-> (out_anim == '0))
    else $error("animation index set without a landing");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("committed frame did not reach the output register");

  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && phase == PH_ON_FACE) |=> (phase != PH_ROLLED))
    else $error("phase jumped from on face straight to rolled");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for throw_detector_roll_fsm_unit
// Drives accelerometer frames on the input stream and predicts every result
// in a scoreboard that tracks the smoothed jerk energy and the roll phase.
// Most frames form throws: a rolling burst of strong jerk, then a quiet
// settle with a face reading. Random frames, extreme register settings,
// random stalls on both streams and one long output hold are mixed in.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tdrf_pkg::*;

  localparam int ACCEL_W   = 12;
  localparam int IN_W      = ((3*JERK_W+3*ACCEL_W+TIME_W+FACE_W+7)/8)*8;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG  = 4000;
  localparam int SETTLE    = 8;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED_B = 3'd7;

  // Field order matches the transfer layout, first field in the lowest bits.
  typedef struct packed {
    logic [FACE_W-1:0]          face;
    logic [TIME_W-1:0]          t;
    logic signed [ACCEL_W-1:0]  az;
    logic signed [ACCEL_W-1:0]  ay;
    logic signed [ACCEL_W-1:0]  ax;
    logic signed [JERK_W-1:0]   jz;
    logic signed [JERK_W-1:0]   jy;
    logic signed [JERK_W-1:0]   jx;
  } frame_t;

  typedef struct {
    logic [ROLL_W-1:0]  roll;
    logic               landed;
    logic [FACE_W-1:0]  anim;
    logic [LEVEL_W-1:0] level;
  } report_t;

  class roll_tracker;
    logic [DECAY_W-1:0] decay_start, decay_stop;
    logic [LEVEL_W-1:0] start_thr, end_thr;
    logic [MS_W-1:0]    min_roll;
    logic [FTH_W-1:0]   face_thr;
    logic [41:0]        energy_avg;
    phase_t             phase;
    logic [TIME_W-1:0]  roll_start;
    report_t            awaited_reports[$];
    int errors, reports_seen, landings, rolls_done, writes_seen;

    function new();
      decay_start = 16'd62259;
      decay_stop  = 16'd62259;
      start_thr   = 26'd1000000;
      end_thr     = 26'd500000;
      min_roll    = 16'd300;
      face_thr    = 11'd1600;
      energy_avg  = '0;
      phase       = PH_ON_FACE;
      roll_start  = '0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      writes_seen++;
      case (idx)
        REG_DECAY_START: decay_start = val[DECAY_W-1:0];
        REG_DECAY_STOP:  decay_stop  = val[DECAY_W-1:0];
        REG_START_THR:   start_thr   = val[LEVEL_W-1:0];
        REG_END_THR:     end_thr     = val[LEVEL_W-1:0];
        REG_MIN_ROLL:    min_roll    = val[MS_W-1:0];
        REG_FACE_THR:    face_thr    = val[FTH_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_frame(frame_t f);
      logic [63:0] energy, target, decay, mixed;
      logic [41:0] start_lvl, end_lvl;
      int jx, jy, jz, ax, ay, az;
      report_t r;
      jx = $signed(f.jx);
      jy = $signed(f.jy);
      jz = $signed(f.jz);
      ax = $signed(f.ax);
      ay = $signed(f.ay);
      az = $signed(f.az);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (az < 0) az = -az;
      energy = 64'(jx*jx + jy*jy + jz*jz);
      target = energy << 16;
      decay = (phase == PH_ROLLED) ? 64'(decay_stop) : 64'(decay_start);
      mixed = (64'(energy_avg) * decay + target * (64'd65536 - decay)) >> 16;
      energy_avg = mixed[41:0];
      start_lvl = {start_thr, 16'b0};
      end_lvl = {end_thr, 16'b0};
      r.landed = 1'b0;
      r.anim = '0;
      case (phase)
        PH_STARTED: begin
          if (energy_avg < start_lvl) begin
            phase = PH_ON_FACE;
          end else if ((f.t - roll_start) > 32'(min_roll)) begin
            phase = PH_ROLLED;
            rolls_done++;
          end
        end
        PH_ROLLED: begin
          if (energy_avg < end_lvl) begin
            phase = PH_ON_FACE;
            if ((ax > int'(face_thr) || ay > int'(face_thr) || az > int'(face_thr)) &&
                f.face < FACE_COUNT) begin
              r.landed = 1'b1;
              r.anim = f.face + ANIM_OFFSET;
              landings++;
            end
          end
        end
        default: begin
          phase = PH_ON_FACE;
          if (energy_avg >= start_lvl) begin
            roll_start = f.t;
            phase = PH_STARTED;
          end
        end
      endcase
      r.roll = phase;
      r.level = energy_avg[41:16];
      awaited_reports.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(logic [OUT_W-1:0] d);
      report_t r;
      reports_seen++;
      if (awaited_reports.size() == 0) begin
        errors++;
        $display("%0t: result with no frame pending, actual %h", $time, d);
      end else begin
        r = awaited_reports.pop_front();
        compare_field("roll_state", r.roll, d[1:0]);
        compare_field("landed", r.landed, d[2]);
        compare_field("anim_index", r.anim, d[7:3]);
        compare_field("energy_level", r.level, d[33:8]);
      end
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  roll_tracker       sb;
  logic [TIME_W-1:0] cur_time = '0;
  bit                allow_idle = 1'b1;
  bit                src_idle = 1'b0;
  bit                hold_req = 1'b0;
  int                quiet_cycles = 0;

  throw_detector_roll_fsm_unit #(
    .ACCEL_BITS(ACCEL_W),
    .FRAC_BITS (16)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_report(m_tdata);
  end

  // Counts cycles without any transfer on either stream.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Output side: random stall bursts, stall-free stretches and one long hold.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [JERK_W-1:0] rand_jerk(int lo, int hi);
    int m;
    m = $urandom_range(lo, hi);
    if ($urandom_range(0, 1) == 1) return JERK_W'(-m);
    return JERK_W'((m > 4095) ? 4095 : m);
  endfunction

  function automatic logic signed [ACCEL_W-1:0] rand_big_accel();
    int m;
    m = $urandom_range(1500, 2048);
    if ($urandom_range(0, 1) == 1) return ACCEL_W'(-m);
    return ACCEL_W'((m > 2047) ? 2047 : m);
  endfunction

  function automatic frame_t mk(int jx, int jy, int jz, int ax, int ay, int az,
                                logic [TIME_W-1:0] t, int face);
    frame_t f;
    f.jx = JERK_W'(jx);
    f.jy = JERK_W'(jy);
    f.jz = JERK_W'(jz);
    f.ax = ACCEL_W'(ax);
    f.ay = ACCEL_W'(ay);
    f.az = ACCEL_W'(az);
    f.t = t;
    f.face = FACE_W'(face);
    return f;
  endfunction

  function automatic logic [TIME_W-1:0] next_time();
    if ($urandom_range(0, 19) == 0) cur_time = cur_time + $urandom;
    else cur_time = cur_time + $urandom_range(1, 40);
    return cur_time;
  endfunction

  // Starts at a rising edge and returns at the edge of the transfer.
  task automatic send_frame(input frame_t f);
    if (src_idle && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(f);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_frame(f);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_all(input int ds, input int dp, input int st, input int et,
                         input int mr, input int ft);
    write_reg(REG_DECAY_START, CFG_W'(ds));
    write_reg(REG_DECAY_STOP, CFG_W'(dp));
    write_reg(REG_START_THR, CFG_W'(st));
    write_reg(REG_END_THR, CFG_W'(et));
    write_reg(REG_MIN_ROLL, CFG_W'(mr));
    write_reg(REG_FACE_THR, CFG_W'(ft));
    cfg_we <= 1'b0;
  endtask

  // Lets every pending result out and the block go idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Throws: strong jerk while rolling, then a quiet settle on one face.
  // Short random runs of arbitrary frames break the sequences now and then.
  task automatic run_throws(input int n);
    int sent, rolls, quiet, k;
    logic [FACE_W-1:0] face;
    frame_t f;
    sent = 0;
    while (sent < n) begin
      src_idle = allow_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          if (sent >= n) break;
          f = frame_t'($bits(frame_t)'({$urandom, $urandom, $urandom, $urandom}));
          send_frame(f);
          sent++;
        end
      end else begin
        rolls = $urandom_range(1, 25);
        quiet = $urandom_range(1, 80);
        if ($urandom_range(0, 4) == 0) face = FACE_W'($urandom_range(20, 31));
        else face = FACE_W'($urandom_range(0, 19));
        repeat (rolls) begin
          if (sent >= n) break;
          f.jx = rand_jerk(1000, 4096);
          f.jy = rand_jerk(1000, 4096);
          f.jz = rand_jerk(0, 4096);
          f.ax = ACCEL_W'($urandom);
          f.ay = ACCEL_W'($urandom);
          f.az = ACCEL_W'($urandom);
          f.t = next_time();
          f.face = FACE_W'($urandom);
          send_frame(f);
          sent++;
        end
        repeat (quiet) begin
          if (sent >= n) break;
          f.jx = rand_jerk(0, 400);
          f.jy = rand_jerk(0, 400);
          f.jz = rand_jerk(0, 400);
          f.ax = ACCEL_W'($urandom_range(0, 255));
          f.ay = ACCEL_W'($urandom);
          f.az = ACCEL_W'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, 2);
            if (k == 0) f.ax = rand_big_accel();
            else if (k == 1) f.ay = rand_big_accel();
            else f.az = rand_big_accel();
          end
          f.t = next_time();
          f.face = face;
          send_frame(f);
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    cur_time = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults from reset.
    run_throws(250);
    drain();

    // Directed frames; no smoothing while rolled so each settle is immediate.
    write_reg(REG_DECAY_STOP, '0);
    cfg_we <= 1'b0;
    src_idle = 1'b0;
    send_frame(mk(0, 0, 0, 0, 0, 0, 32'd0, 0));
    // A roll that starts just before the timestamp wraps.
    send_frame(mk(-4096, -4096, -4096, 2047, 2047, 2047, 32'hFFFF_FF00, 19));
    send_frame(mk(4095, 4095, 4095, -2048, -2048, -2048, 32'hFFFF_FFFF, 31));
    send_frame(mk(4095, -4096, 0, 0, 0, 0, 32'h0000_002D, 5));
    send_frame(mk(0, 0, 0, -2048, 0, 0, 32'h0000_0040, 19));
    // Settle with a face index past the face count.
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd1000, 0));
    send_frame(mk(-4096, 4095, -4096, 0, 0, 0, 32'd1301, 0));
    send_frame(mk(0, 0, 0, 2047, 2047, 2047, 32'd1302, 20));
    // Acceleration exactly at the face threshold does not count.
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd2000, 0));
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd2400, 0));
    send_frame(mk(1, -1, 0, 1600, -1600, 1600, 32'd2401, 3));
    send_frame(mk(-4096, -4096, 4095, 0, 0, 0, 32'd3000, 7));
    send_frame(mk(4095, -4096, 4095, 0, 0, 0, 32'd3400, 7));
    send_frame(mk(0, 0, 0, 0, 1601, 0, 32'd3401, 0));
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd4000, 1));
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd4400, 1));
    send_frame(mk(0, 0, 0, 0, 0, -1601, 32'd4401, 31));
    // Roll time exactly at the minimum does not advance the phase.
    send_frame(mk(4095, 4095, 4095, 0, 0, 0, 32'd5000, 2));
    send_frame(mk(3000, 3000, 3000, 0, 0, 0, 32'd5100, 2));
    send_frame(mk(3000, -3000, 3000, 0, 0, 0, 32'd5300, 2));
    send_frame(mk(3000, 3000, -3000, 0, 0, 0, 32'd5301, 2));
    send_frame(mk(0, 0, 0, 0, 2047, 0, 32'd5302, 10));
    drain();

    // No smoothing at all, zero roll time and zero face threshold.
    set_all(0, 0, 1000000, 900000, 0, 0);
    run_throws(200);
    drain();

    // Slowest smoothing, roll starts at once, ends at once, longest roll time.
    set_all(65535, 65535, 0, 67108863, 65535, 2047);
    run_throws(150);
    drain();

    // Oversized values keep only the register width; unused indexes do nothing.
    write_reg(REG_DECAY_START, {10'h3FF, 16'($urandom_range(40000, 65535))});
    write_reg(REG_DECAY_STOP, {10'h2AA, 16'($urandom)});
    write_reg(REG_START_THR, 26'h3FF_FFFF);
    write_reg(REG_END_THR, CFG_W'($urandom));
    write_reg(REG_MIN_ROLL, {10'h155, 16'($urandom_range(0, 600))});
    write_reg(REG_FACE_THR, {15'h7FFF, 11'($urandom)});
    write_reg(REG_UNUSED_A, CFG_W'($urandom));
    write_reg(REG_UNUSED_B, CFG_W'($urandom));
    cfg_we <= 1'b0;
    run_throws(150);
    drain();

    for (int p = 0; p < 3; p++) begin
      if (p == 0) hold_req = 1'b1;
      if (p == 2) allow_idle = 1'b0;
      set_all($urandom_range(55000, 65535), $urandom_range(30000, 65535),
              $urandom_range(200000, 4000000), $urandom_range(50000, 200000),
              $urandom_range(0, 500), $urandom_range(1000, 2047));
      run_throws(250);
      drain();
    end

    $display("Run summary: %0d results checked, %0d rolls completed, %0d landings flagged.",
             sb.reports_seen, sb.rolls_done, sb.landings);
    $display("Register writes: %0d; mismatches: %0d.", sb.writes_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
